FILE: rtl/hrod_pkg.sv
// hrod_pkg: widths, register indexes, reset values and cell control struct
// for the heat rod explicit step block; depends on nothing
package hrod_pkg;

	localparam int TEMP_W    = 16;
	localparam int GAIN_W    = 16;
	localparam int LAP_W     = TEMP_W + 2;
	localparam int PROD_W    = LAP_W + GAIN_W + 1;
	localparam int DELTA_W   = PROD_W - 16;
	localparam int IDX_OUT_W = 6;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_BOUNDARY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_BOUNDARY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TEMP   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION_GAIN = 2'd3;

	localparam logic [TEMP_W-1:0] RST_LEFT_BOUNDARY  = 16'd25600;
	localparam logic [TEMP_W-1:0] RST_RIGHT_BOUNDARY = 16'd6400;
	localparam logic [TEMP_W-1:0] RST_INITIAL_TEMP   = 16'd6400;
	localparam logic [GAIN_W-1:0] RST_DIFFUSION_GAIN = 16'd6554;
	localparam logic [TEMP_W-1:0] RST_CELL_TEMP      = 16'd6400;

	typedef struct packed {
		logic load_init;
		logic shift;
		logic calc_lap;
		logic calc_mul;
		logic calc_upd;
	} cell_ctrl_t;

endpackage

FILE: rtl/hrod_if.sv
// hrod_in_if / hrod_out_if: valid-ready channels of the heat rod block
// depends on hrod_pkg for field widths
interface hrod_in_if;
	logic valid;
	logic ready;
	logic restart;
	logic report;

	modport source (output valid, output restart, output report, input ready);
	modport sink (input valid, input restart, input report, output ready);
endinterface

interface hrod_out_if;
	logic                               valid;
	logic                               ready;
	logic [hrod_pkg::IDX_OUT_W-1:0]     cell_index;
	logic [hrod_pkg::TEMP_W-1:0]        temperature;
	logic                               last;

	modport source (output valid, output cell_index, output temperature, output last,
		input ready);
	modport sink (input valid, input cell_index, input temperature, input last,
		output ready);
endinterface

FILE: rtl/hrod_cell.sv
// hrod_cell: one rod cell, holds its temperature and runs its own update
// in three registered steps; depends on hrod_pkg
module hrod_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hrod_pkg::cell_ctrl_t        ctrl,
	input  logic [hrod_pkg::TEMP_W-1:0] init_temp,
	input  logic [hrod_pkg::GAIN_W-1:0] gain,
	input  logic [hrod_pkg::TEMP_W-1:0] left_temp,
	input  logic [hrod_pkg::TEMP_W-1:0] right_temp,
	input  logic [hrod_pkg::TEMP_W-1:0] shift_in,
	output logic [hrod_pkg::TEMP_W-1:0] temp
);
	import hrod_pkg::*;

	logic        [TEMP_W-1:0]  temp_q;
	logic signed [LAP_W-1:0]   lap_q;
	logic signed [DELTA_W-1:0] delta_q;
	logic        [LAP_W-1:0]   lap_d;
	logic signed [PROD_W-1:0]  prod;
	logic signed [DELTA_W:0]   sum;
	logic        [TEMP_W-1:0]  sat;

	// left + right - 2c, fits 18 bits signed
	assign lap_d = LAP_W'(left_temp) + LAP_W'(right_temp) - {1'b0, temp_q, 1'b0};
	assign prod  = lap_q * $signed({1'b0, gain});
	assign sum   = $signed({{(DELTA_W + 1 - TEMP_W){1'b0}}, temp_q})
		+ $signed({delta_q[DELTA_W-1], delta_q});

	always_comb begin
		if (sum < 0) begin
			sat = '0;
		end else if (sum > $signed({{(DELTA_W + 1 - TEMP_W){1'b0}}, {TEMP_W{1'b1}}})) begin
			sat = '1;
		end else begin
			sat = sum[TEMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= RST_CELL_TEMP;
		end else if (ctrl.load_init) begin
			temp_q <= init_temp;
		end else if (ctrl.shift) begin
			temp_q <= shift_in;
		end else if (ctrl.calc_upd) begin
			temp_q <= sat;
		end
	end

	// arithmetic shift by 16 is the part-select of the signed product
	always_ff @(posedge clk) begin
		if (ctrl.calc_lap) begin
			lap_q <= $signed(lap_d);
		end
		if (ctrl.calc_mul) begin
			delta_q <= prod[PROD_W-1:16];
		end
	end

	assign temp = temp_q;
endmodule

FILE: rtl/heat_rod_explicit_step_top.sv
// heat_rod_explicit_step_top: rod of hrod_cell instances, config registers,
// step sequencer and report output register; depends on hrod_pkg, hrod_if, hrod_cell
// step: the input word starts the laplacian, product and update states in order;
//   a restart loads every cell in the accepting cycle
// report: CELLS result words, one per cycle unless the output stalls, the first one
//   loaded after the update (or the restart); the chain rotates one cell per word
// input: taken only when idle; a new word waits for the previous step and its report
// reset: asynchronous, all cells at 25.0, registers at their reset values
module heat_rod_explicit_step_top #(
	parameter int CELLS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	hrod_in_if.sink                        in_ch,
	hrod_out_if.source                     out_ch,
	input  logic                           cfg_we,
	input  logic [hrod_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [hrod_pkg::TEMP_W-1:0]    cfg_wdata
);
	import hrod_pkg::*;

	localparam int CNT_W = $clog2(CELLS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CELLS - 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LAP  = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_UPD  = 5'b01000,
		ST_RPT  = 5'b10000
	} state_t;

	// configuration registers
	logic [TEMP_W-1:0] left_boundary_q;
	logic [TEMP_W-1:0] right_boundary_q;
	logic [TEMP_W-1:0] initial_temp_q;
	logic [GAIN_W-1:0] diffusion_gain_q;

	// sequencer
	state_t            state_q;
	logic              report_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              in_acc;
	logic              out_load;
	cell_ctrl_t        ctrl;

	// output register
	logic              out_valid_q;
	logic [CNT_W-1:0]  out_idx_q;
	logic [TEMP_W-1:0] out_temp_q;
	logic              out_last_q;

	// the rod
	logic [TEMP_W-1:0] temps [CELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_boundary_q  <= RST_LEFT_BOUNDARY;
			right_boundary_q <= RST_RIGHT_BOUNDARY;
			initial_temp_q   <= RST_INITIAL_TEMP;
			diffusion_gain_q <= RST_DIFFUSION_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_LEFT_BOUNDARY:  left_boundary_q  <= cfg_wdata;
				CFG_RIGHT_BOUNDARY: right_boundary_q <= cfg_wdata;
				CFG_INITIAL_TEMP:   initial_temp_q   <= cfg_wdata;
				CFG_DIFFUSION_GAIN: diffusion_gain_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input is taken only between items; the last report word may still be waiting
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;

	// a report word moves into the output register whenever it is free
	assign out_load = (state_q == ST_RPT) && (!out_valid_q || out_ch.ready);

	always_comb begin
		ctrl           = '0;
		ctrl.load_init = in_acc && in_ch.restart;
		ctrl.calc_lap  = (state_q == ST_LAP);
		ctrl.calc_mul  = (state_q == ST_MUL);
		ctrl.calc_upd  = (state_q == ST_UPD);
		ctrl.shift     = out_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			report_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						report_q <= in_ch.report;
						cnt_q    <= '0;
						if (!in_ch.restart) begin
							state_q <= ST_LAP;
						end else if (in_ch.report) begin
							state_q <= ST_RPT;
						end
					end
				end
				ST_LAP: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_UPD;
				ST_UPD: state_q <= report_q ? ST_RPT : ST_IDLE;
				ST_RPT: begin
					if (out_load) begin
						if (cnt_q == CNT_LAST) begin
							cnt_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// cell 0 always sits at the head of the rotating chain
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q  <= cnt_q;
			out_temp_q <= temps[0];
			out_last_q <= (cnt_q == CNT_LAST);
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.cell_index  = IDX_OUT_W'(out_idx_q);
	assign out_ch.temperature = out_temp_q;
	assign out_ch.last        = out_last_q;

	// chain: neighbours for the stencil, rotation towards cell 0 for reporting
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		logic [TEMP_W-1:0] left_nb;
		logic [TEMP_W-1:0] right_nb;
		logic [TEMP_W-1:0] rot_in;

		if (i == 0) begin : g_first
			assign left_nb = left_boundary_q;
		end else begin : g_inner_l
			assign left_nb = temps[i-1];
		end

		if (i == CELLS - 1) begin : g_final
			assign right_nb = right_boundary_q;
			assign rot_in   = temps[0];
		end else begin : g_inner_r
			assign right_nb = temps[i+1];
			assign rot_in   = temps[i+1];
		end

		hrod_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.init_temp  (initial_temp_q),
			.gain       (diffusion_gain_q),
			.left_temp  (left_nb),
			.right_temp (right_nb),
			.shift_in   (rot_in),
			.temp       (temps[i])
		);
	end
endmodule

FILE: rtl/hrod_chk.sv
// hrod_chk: port-level checks on the heat rod block, bound to the top level
// depends on hrod_pkg and heat_rod_explicit_step_top
module hrod_chk #(
	parameter int CELLS = 16
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [hrod_pkg::IDX_OUT_W-1:0] out_cell_index,
	input logic [hrod_pkg::TEMP_W-1:0]    out_temperature,
	input logic                           out_last
);
	import hrod_pkg::*;

	localparam logic [IDX_OUT_W-1:0] IDX_LAST = IDX_OUT_W'(CELLS - 1);

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_cell_index)
			&& $stable(out_temperature) && $stable(out_last))
		else $error("output word changed while stalled");

	// last flag marks exactly the final cell
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == (out_cell_index == IDX_LAST)))
		else $error("last flag and cell index disagree");

	// a report run has no gaps
	a_run_dense: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("gap inside a report run");

	// no new item while a run is under way
	a_busy_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("input taken in the middle of a report run");
endmodule

bind heat_rod_explicit_step_top hrod_chk #(.CELLS(CELLS)) u_hrod_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.out_cell_index  (out_ch.cell_index),
	.out_temperature (out_ch.temperature),
	.out_last        (out_ch.last)
);
